// ----- rtl/core/segtree_pkg.sv -----
`default_nettype none

package segtree_pkg;

  localparam int TREE_BASE = 1024;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 10;
  localparam int NODE_W    = $clog2(2 * TREE_BASE);
  localparam int ROW_COUNT = TREE_BASE;
  localparam int ROW_W     = NODE_W - 1;

  localparam logic [IDX_W-1:0]  LAST_POS  = IDX_W'(TREE_BASE - 3);
  localparam logic [DATA_W-1:0] MAX_FLOOR = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FN_SET = 2'd0,
    FN_SUM = 2'd1,
    FN_MAX = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_CLIMB,
    ST_QUERY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic leaf_write;
    logic climb;
    logic query;
    logic res_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic clear_last;
    logic req_bad;
    logic req_set;
    logic climb_last;
    logic query_last;
  } dp_stat_t;

  function automatic logic [DATA_W-1:0] smax(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/segtree_ifs.sv -----
`default_nettype none

interface segtree_cmd_if import segtree_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic [IDX_W-1:0]         left_index;
  logic [IDX_W-1:0]         right_index;
  logic signed [DATA_W-1:0] new_value;

  modport source (output valid, func, left_index, right_index, new_value,
                  input ready);
  modport sink (input valid, func, left_index, right_index, new_value,
                output ready);
endinterface

interface segtree_res_if import segtree_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] answer;
  logic                     bad_request;

  modport source (output valid, answer, bad_request, input ready);
  modport sink (input valid, answer, bad_request, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/segtree_ctrl.sv -----
`default_nettype none

module segtree_ctrl import segtree_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  output logic     res_valid,
  input  logic     res_ready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  state_t state, state_next;
  logic   out_valid;
  logic   accept;
  logic   res_free;

  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign res_free  = !out_valid || res_ready;
  assign res_valid = out_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (stat.req_bad) state_next = ST_FINISH;
          else if (stat.req_set) state_next = ST_LEAF;
          else state_next = ST_QUERY;
        end
      end
      ST_LEAF:  state_next = ST_CLIMB;
      ST_CLIMB: begin
        if (stat.climb_last) state_next = ST_FINISH;
      end
      ST_QUERY: begin
        if (stat.query_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      ST_CLEAR:  ctrl.clear_en   = 1'b1;
      ST_IDLE:   ctrl.load       = accept;
      ST_LEAF:   ctrl.leaf_write = 1'b1;
      ST_CLIMB:  ctrl.climb      = 1'b1;
      ST_QUERY:  ctrl.query      = 1'b1;
      ST_FINISH: ctrl.res_load   = res_free;
      default:   ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.res_load) out_valid <= 1'b1;
      else if (res_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/segtree_dp.sv -----
`default_nettype none

module segtree_dp import segtree_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               func,
  input  logic [IDX_W-1:0]         left_index,
  input  logic [IDX_W-1:0]         right_index,
  input  logic signed [DATA_W-1:0] new_value,
  input  dp_ctrl_t                 ctrl,
  output dp_stat_t                 stat,
  output logic signed [DATA_W-1:0] answer,
  output logic                     bad_request
);

  // node n lives in the even or odd bank by n[0], at row n >> 1
  logic [DATA_W-1:0] sum_even [ROW_COUNT];
  logic [DATA_W-1:0] sum_odd  [ROW_COUNT];
  logic [DATA_W-1:0] max_even [ROW_COUNT];
  logic [DATA_W-1:0] max_odd  [ROW_COUNT];

  logic [DATA_W-1:0] rd_sum_even, rd_sum_odd, rd_max_even, rd_max_odd;

  logic [ROW_W-1:0]  clr_row;
  logic [NODE_W-1:0] nd, s, t;
  logic [DATA_W-1:0] cur_sum, cur_max, acc;
  logic              pend_s, pend_t;
  logic              set_q, bad_q, sum_q;

  logic              func_ok;
  logic              cond;
  logic [NODE_W-1:0] wnode;
  logic [ROW_W-1:0]  wrow, raddr_even, raddr_odd;
  logic              we_even, we_odd;
  logic [DATA_W-1:0] wsum, wmax;
  logic [DATA_W-1:0] sib_sum, sib_max, par_sum, par_max;
  logic [DATA_W-1:0] qa, qb, acc_next, max_mid;

  assign func_ok = (func == FN_SET) || (func == FN_SUM) || (func == FN_MAX);

  assign stat.req_bad    = !func_ok || (left_index > LAST_POS) ||
                           ((func != FN_SET) &&
                            ((right_index > LAST_POS) || (left_index > right_index)));
  assign stat.req_set    = (func == FN_SET);
  assign stat.clear_last = (clr_row == ROW_W'(ROW_COUNT - 1));
  assign stat.climb_last = (nd[NODE_W-1:1] == ROW_W'(1));
  assign stat.query_last = !cond;

  // open-interval walk continues until the bounds are siblings
  assign cond = ((s ^ t) != NODE_W'(1)) && (t > NODE_W'(1));

  // climb: combine the running node with its sibling
  assign sib_sum = nd[0] ? rd_sum_even : rd_sum_odd;
  assign sib_max = nd[0] ? rd_max_even : rd_max_odd;
  assign par_sum = cur_sum + sib_sum;
  assign par_max = smax(cur_max, sib_max);

  assign wnode   = ctrl.leaf_write ? nd : {1'b0, nd[NODE_W-1:1]};
  assign wrow    = ctrl.clear_en ? clr_row : wnode[NODE_W-1:1];
  assign we_even = ctrl.clear_en || ((ctrl.leaf_write || ctrl.climb) && !wnode[0]);
  assign we_odd  = ctrl.clear_en || ((ctrl.leaf_write || ctrl.climb) && wnode[0]);
  assign wsum    = ctrl.clear_en ? '0 : (ctrl.leaf_write ? cur_sum : par_sum);
  assign wmax    = ctrl.clear_en ? '0 : (ctrl.leaf_write ? cur_max : par_max);

  always_comb begin
    if (ctrl.query) begin
      raddr_odd  = s[NODE_W-1:1];
      raddr_even = t[NODE_W-1:1];
    end else if (ctrl.climb) begin
      raddr_odd  = {1'b0, nd[NODE_W-1:2]};
      raddr_even = {1'b0, nd[NODE_W-1:2]};
    end else begin
      raddr_odd  = nd[NODE_W-1:1];
      raddr_even = nd[NODE_W-1:1];
    end
  end

  // left bound takes the odd sibling, right bound the even one
  assign qa      = sum_q ? rd_sum_odd : rd_max_odd;
  assign qb      = sum_q ? rd_sum_even : rd_max_even;
  assign max_mid = pend_s ? smax(acc, qa) : acc;

  always_comb begin
    if (sum_q) begin
      acc_next = acc + (pend_s ? qa : '0) + (pend_t ? qb : '0);
    end else begin
      acc_next = pend_t ? smax(max_mid, qb) : max_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (we_even) begin
      sum_even[wrow] <= wsum;
      max_even[wrow] <= wmax;
    end
    if (we_odd) begin
      sum_odd[wrow] <= wsum;
      max_odd[wrow] <= wmax;
    end
    rd_sum_even <= sum_even[raddr_even];
    rd_max_even <= max_even[raddr_even];
    rd_sum_odd  <= sum_odd[raddr_odd];
    rd_max_odd  <= max_odd[raddr_odd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (ctrl.clear_en) begin
      clr_row <= clr_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      set_q   <= (func == FN_SET);
      sum_q   <= (func == FN_SUM);
      bad_q   <= stat.req_bad;
      nd      <= NODE_W'(left_index) + NODE_W'(TREE_BASE + 1);
      s       <= NODE_W'(left_index) + NODE_W'(TREE_BASE);
      t       <= NODE_W'(right_index) + NODE_W'(TREE_BASE + 2);
      cur_sum <= new_value;
      cur_max <= new_value;
      acc     <= (func == FN_SUM) ? '0 : MAX_FLOOR;
      pend_s  <= 1'b0;
      pend_t  <= 1'b0;
    end
    if (ctrl.climb) begin
      nd      <= {1'b0, nd[NODE_W-1:1]};
      cur_sum <= par_sum;
      cur_max <= par_max;
    end
    if (ctrl.query) begin
      acc    <= acc_next;
      pend_s <= cond && !s[0];
      pend_t <= cond && t[0];
      if (cond) begin
        s <= {1'b0, s[NODE_W-1:1]};
        t <= {1'b0, t[NODE_W-1:1]};
      end
    end
    if (ctrl.res_load) begin
      answer      <= (bad_q || set_q) ? '0 : acc;
      bad_request <= bad_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/segment_tree_sum_max.sv -----
// channel  dir  fields                                          handshake
// cmd      in   func, left_index, right_index, new_value        valid/ready
// res      out  answer, bad_request                             valid/ready
//
// one item in flight; a set goes from acceptance to result through the leaf write,
// one tree level per climb step through the shared sibling read, then the result slot
// queries walk one tree level per step; rejected items go straight to the result slot
// after reset the node memories are cleared one row a cycle, all 1024 rows, cmd.ready low
// a result waits in its output register while the next item is accepted
// a stalled result holds the following item in its final cycle until the slot frees
`default_nettype none

module segment_tree_sum_max import segtree_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  segtree_cmd_if.sink  cmd,
  segtree_res_if.source res
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  segtree_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  segtree_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .func        (cmd.func),
    .left_index  (cmd.left_index),
    .right_index (cmd.right_index),
    .new_value   (cmd.new_value),
    .ctrl        (ctrl),
    .stat        (stat),
    .answer      (res.answer),
    .bad_request (res.bad_request)
  );

endmodule

`default_nettype wire

// ----- rtl/core/segtree_checker.sv -----
`default_nettype none

module segtree_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] answer,
  input logic        bad_request
);

  // a waiting result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(answer) && $stable(bad_request))
    else $error("result changed while stalled");

  // clearing pass keeps the command side closed right after reset
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !cmd_ready)
    else $error("command accepted during memory clear");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second item taken while busy");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && bad_request |-> answer == 32'd0)
    else $error("rejected item with nonzero answer");

endmodule

bind segment_tree_sum_max segtree_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .answer      (res.answer),
  .bad_request (res.bad_request)
);

`default_nettype wire
